[src/packet_checksum_inorder_receiver_defines.svh]
// ----------------------------------------------------------------------------
// packet_checksum_inorder_receiver_defines.svh
// Assertion macros shared by the receiver's checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_CHECKSUM_INORDER_RECEIVER_DEFINES_SVH
`define PACKET_CHECKSUM_INORDER_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PCIR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PCIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pcir_pkg.sv]
// ----------------------------------------------------------------------------
// pcir_pkg
// Widths shared by the in-order receiver, its channels and its checker.
// ----------------------------------------------------------------------------
package pcir_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned SEQ_W   = 32;
	// six 16-bit terms summed at packet end need three growth bits
	localparam int unsigned SUM_W   = WORD_W + 3;
	localparam int unsigned GROW_W  = SUM_W - WORD_W;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SEQ_W-1:0]  seq_t;

endpackage

[src/pcir_if.sv]
// ----------------------------------------------------------------------------
// pcir_if
// Valid/ready channels of the receiver: payload items, results, config.
// ----------------------------------------------------------------------------
interface pcir_item_if;
	logic              valid;
	logic              ready;
	pcir_pkg::byte_t   data_byte;
	logic              byte_present;
	logic              last_item;
	pcir_pkg::seq_t    rx_sequence;
	pcir_pkg::seq_t    rx_acknowledge;
	pcir_pkg::word_t   rx_check;

	modport source (output valid, data_byte, byte_present, last_item,
		rx_sequence, rx_acknowledge, rx_check, input ready);
	modport sink (input valid, data_byte, byte_present, last_item,
		rx_sequence, rx_acknowledge, rx_check, output ready);
endinterface

interface pcir_result_if;
	logic              valid;
	logic              ready;
	pcir_pkg::seq_t    ack_number;
	logic              accepted;
	pcir_pkg::word_t   computed_check;

	modport source (output valid, ack_number, accepted, computed_check, input ready);
	modport sink (input valid, ack_number, accepted, computed_check, output ready);
endinterface

interface pcir_cfg_if;
	logic              valid;
	logic              ready;
	pcir_pkg::seq_t    data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/packet_checksum_inorder_receiver.sv]
// ----------------------------------------------------------------------------
// packet_checksum_inorder_receiver
// In-order (go-back-N) packet receiver with a one's complement checksum.
// ----------------------------------------------------------------------------
//  channel   dir  carries
//  item      in   at most one payload byte per item; header on the last item
//  result    out  ack_number, accepted, computed_check; one per packet
//  cfg       in   start_sequence write (loads the expected sequence)
//
//  One item per cycle while the input is not stalled. A result passes the
//  input register, then one pass of pairing, a 16-bit end-around add and
//  the packet-end fold, on its way into the result register.
//  Reset clears the packet sum and sets the expected sequence to zero.
//  Input stalls only while the input register holds a last item and the
//  result register is still full and not taken.
// ----------------------------------------------------------------------------
module packet_checksum_inorder_receiver (
	input  logic             clk,
	input  logic             arst_n,
	pcir_item_if.sink        item,
	pcir_result_if.source    result,
	pcir_cfg_if.sink         cfg
);

	// input register
	logic                v_s1;
	pcir_pkg::byte_t     byte_s1;
	logic                present_s1;
	logic                last_s1;
	pcir_pkg::seq_t      seq_s1;
	pcir_pkg::seq_t      ackn_s1;
	pcir_pkg::word_t     chk_s1;

	// packet and link state
	pcir_pkg::word_t     sum_q;
	logic                odd_q;
	pcir_pkg::byte_t     held_q;
	pcir_pkg::seq_t      exp_q;

	// result register
	logic                out_valid_q;
	pcir_pkg::seq_t      ack_q;
	logic                acc_q;
	pcir_pkg::word_t     comp_q;

	logic                adv_s1;
	logic                in_take;
	pcir_pkg::word_t     pair_word;
	logic [pcir_pkg::WORD_W:0] run_add;
	pcir_pkg::word_t     run_next;
	pcir_pkg::word_t     pay_word;
	logic [pcir_pkg::SUM_W-1:0] total;
	logic [pcir_pkg::WORD_W:0]  fold1;
	pcir_pkg::word_t     fold2;
	pcir_pkg::word_t     comp;
	logic                ok;

	// handshakes
	assign adv_s1      = v_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign item.ready  = !v_s1 || adv_s1;
	assign in_take     = item.valid && item.ready;
	assign cfg.ready   = 1'b1;

	assign result.valid          = out_valid_q;
	assign result.ack_number     = ack_q;
	assign result.accepted       = acc_q;
	assign result.computed_check = comp_q;

	// running sum: completed byte pair, low byte first, end-around carry
	assign pair_word = {byte_s1, held_q};
	assign run_add   = {1'b0, sum_q} + {1'b0, pair_word};
	assign run_next  = run_add[pcir_pkg::WORD_W-1:0]
		+ {{(pcir_pkg::WORD_W-1){1'b0}}, run_add[pcir_pkg::WORD_W]};

	// payload word still open at packet end (pair or lone byte)
	always_comb begin
		if (present_s1) begin
			pay_word = odd_q ? pair_word : {{pcir_pkg::BYTE_W{1'b0}}, byte_s1};
		end else begin
			pay_word = odd_q ? {{pcir_pkg::BYTE_W{1'b0}}, held_q} : '0;
		end
	end

	// packet end: add header halves, fold twice, complement
	assign total = {{pcir_pkg::GROW_W{1'b0}}, sum_q}
		+ {{pcir_pkg::GROW_W{1'b0}}, pay_word}
		+ {{pcir_pkg::GROW_W{1'b0}}, seq_s1[pcir_pkg::SEQ_W-1:pcir_pkg::WORD_W]}
		+ {{pcir_pkg::GROW_W{1'b0}}, seq_s1[pcir_pkg::WORD_W-1:0]}
		+ {{pcir_pkg::GROW_W{1'b0}}, ackn_s1[pcir_pkg::SEQ_W-1:pcir_pkg::WORD_W]}
		+ {{pcir_pkg::GROW_W{1'b0}}, ackn_s1[pcir_pkg::WORD_W-1:0]};
	assign fold1 = {1'b0, total[pcir_pkg::WORD_W-1:0]}
		+ {{(pcir_pkg::WORD_W+1-pcir_pkg::GROW_W){1'b0}},
			total[pcir_pkg::SUM_W-1:pcir_pkg::WORD_W]};
	assign fold2 = fold1[pcir_pkg::WORD_W-1:0]
		+ {{(pcir_pkg::WORD_W-1){1'b0}}, fold1[pcir_pkg::WORD_W]};
	assign comp  = ~fold2;
	assign ok    = (comp == chk_s1) && (seq_s1 == exp_q);

	// input register payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1    <= item.data_byte;
			present_s1 <= item.byte_present;
			last_s1    <= item.last_item;
			seq_s1     <= item.rx_sequence;
			ackn_s1    <= item.rx_acknowledge;
			chk_s1     <= item.rx_check;
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	// packet state and expected sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			odd_q  <= 1'b0;
			held_q <= '0;
			exp_q  <= '0;
		end else begin
			if (adv_s1) begin
				if (last_s1) begin
					sum_q  <= '0;
					odd_q  <= 1'b0;
					held_q <= '0;
				end else if (present_s1) begin
					if (!odd_q) begin
						held_q <= byte_s1;
						odd_q  <= 1'b1;
					end else begin
						sum_q  <= run_next;
						odd_q  <= 1'b0;
						held_q <= '0;
					end
				end
			end
			if (cfg.valid) begin
				exp_q <= cfg.data;
			end else if (adv_s1 && last_s1 && ok) begin
				exp_q <= exp_q + 1'b1;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			ack_q  <= ok ? exp_q : exp_q - 1'b1;
			acc_q  <= ok;
			comp_q <= comp;
		end
	end

endmodule

[src/pcir_checker.sv]
// ----------------------------------------------------------------------------
// pcir_checker
// Port-level checks of the in-order receiver, bound to its top level.
// ----------------------------------------------------------------------------
`include "packet_checksum_inorder_receiver_defines.svh"

module pcir_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  logic             item_last,
	input  logic             out_valid,
	input  logic             out_ready,
	input  pcir_pkg::seq_t   out_ack,
	input  logic             out_accepted,
	input  pcir_pkg::word_t  out_check
);

	// a fresh result comes only from a taken last item, through the input register
	`PCIR_ASSERT_SAME(a_result_from_last, clk, arst_n, $rose(out_valid), $past(item_valid && item_ready && item_last, 2), "result without a last item")

	// input backs up only behind a full, untaken result register
	`PCIR_ASSERT_SAME(a_stall_cause, clk, arst_n, !item_ready, out_valid && !out_ready, "input stalled with output free")

	// a stalled result stays offered
	`PCIR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// a stalled result keeps its payload
	`PCIR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_ack) && $stable(out_accepted) && $stable(out_check), "result changed while stalled")

endmodule

bind packet_checksum_inorder_receiver pcir_checker u_pcir_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_last    (item.last_item),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_ack      (result.ack_number),
	.out_accepted (result.accepted),
	.out_check    (result.computed_check)
);
